// ----- hdl/hcmg_pkg.sv -----
// Types, codes and pattern tables for the Hilbert curve move generator.
// No dependencies; imported by hilbert_curve_move_generator.
package hcmg_pkg;

  typedef enum logic [1:0] {
    KIND_A = 2'd0,
    KIND_B = 2'd1,
    KIND_C = 2'd2,
    KIND_D = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_POP  = 2'd2
  } state_e;

  localparam logic       REQ_START  = 1'b0;
  localparam logic       REQ_NEXT   = 1'b1;
  localparam logic [2:0] PHASE_DONE = 3'd7;
  localparam logic [2:0] PHASE_TAIL = 3'd6;
  localparam logic [1:0] MOVE_TAIL  = 2'd2;

  typedef struct packed {
    logic       spine;
    kind_e      kind;
    logic [2:0] phase;
  } frame_t;

  function automatic kind_e child_kind(kind_e kind, logic [1:0] call_idx);
    kind_e res;
    res = kind;
    case (kind)
      KIND_A: begin
        case (call_idx)
          2'd0:    res = KIND_D;
          2'd3:    res = KIND_B;
          default: res = KIND_A;
        endcase
      end
      KIND_B: begin
        case (call_idx)
          2'd0:    res = KIND_C;
          2'd3:    res = KIND_A;
          default: res = KIND_B;
        endcase
      end
      KIND_C: begin
        case (call_idx)
          2'd0:    res = KIND_B;
          2'd3:    res = KIND_D;
          default: res = KIND_C;
        endcase
      end
      default: begin
        case (call_idx)
          2'd0:    res = KIND_A;
          2'd3:    res = KIND_C;
          default: res = KIND_D;
        endcase
      end
    endcase
    return res;
  endfunction

  function automatic dir_e move_dir(kind_e kind, logic [1:0] move_idx);
    dir_e res;
    res = DIR_LEFT;
    case (kind)
      KIND_A: begin
        case (move_idx)
          2'd0:    res = DIR_LEFT;
          2'd1:    res = DIR_DOWN;
          default: res = DIR_RIGHT;
        endcase
      end
      KIND_B: begin
        case (move_idx)
          2'd0:    res = DIR_UP;
          2'd1:    res = DIR_RIGHT;
          default: res = DIR_DOWN;
        endcase
      end
      KIND_C: begin
        case (move_idx)
          2'd0:    res = DIR_RIGHT;
          2'd1:    res = DIR_UP;
          default: res = DIR_LEFT;
        endcase
      end
      default: begin
        case (move_idx)
          2'd0:    res = DIR_DOWN;
          2'd1:    res = DIR_LEFT;
          default: res = DIR_UP;
        endcase
      end
    endcase
    return res;
  endfunction

endpackage

// ----- hdl/hilbert_curve_move_generator.sv -----
// Hilbert curve move generator: frame stack in a one-port synchronous memory,
// top frame cached in registers. Depends on hcmg_pkg.
//
// channel  dir  handshake                      payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tuser: req_type; tdata: order, kind, length
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: dx, dy; tlast: last_move
//
// A start word gives no result. A next word walks the stack frames, one frame
// step per cycle unless the output stalls: call steps push frames, each unwind
// pops a finished frame and reloads its parent from memory in ST_POP, and a
// move step ends the walk with one output word. Reset clears control state; the
// frame memory is not cleared. A stalled output word holds the walk before its move step.
module hilbert_curve_move_generator #(
  parameter int MAX_ORDER = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [4:0] curve_order, [6:5] curve_kind,
                                     // [22:7] segment_length, [23] zero
  input  logic [0:0]  s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [16:0] move_dx, [33:17] move_dy, [39:34] zero
  output logic        m_axis_tlast   // last_move
);
  import hcmg_pkg::*;

  localparam int DW = $clog2(MAX_ORDER + 1);
  localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  state_e          state_q, state_d;
  kind_e           top_kind_q, top_kind_d;
  logic [2:0]      top_phase_q, top_phase_d;
  logic            top_spine_q, top_spine_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic [DW-1:0]   held_order_q, held_order_d;
  logic [15:0]     held_length_q, held_length_d;
  logic            active_q, active_d;
  logic            out_valid_q, out_valid_d;
  logic [16:0]     out_dx_q, out_dx_d;
  logic [16:0]     out_dy_q, out_dy_d;
  logic            out_last_q, out_last_d;

  frame_t          frame_mem [MAX_ORDER];
  frame_t          rd_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  frame_t          mem_wdata;

  logic            in_fire, out_free, at_leaf, is_last;
  logic [4:0]      in_order;
  logic [DW-1:0]   depth_dec, depth_dec2;
  logic [16:0]     len_pos, len_neg;
  dir_e            dir;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign in_order   = s_axis_tdata[4:0];
  assign depth_dec  = depth_q - DW'(1);
  assign depth_dec2 = depth_q - DW'(2);
  assign at_leaf    = (depth_q >= held_order_q);
  assign is_last    = (top_phase_q[2:1] == MOVE_TAIL) && at_leaf && top_spine_q;
  assign len_pos    = {1'b0, held_length_q};
  assign len_neg    = 17'd0 - len_pos;
  assign dir        = move_dir(top_kind_q, top_phase_q[2:1]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_dy_q, out_dx_q};
  assign m_axis_tlast  = out_last_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser[0] == REQ_NEXT && active_q) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (top_phase_q == PHASE_DONE) begin
          state_d = (depth_q == DW'(1)) ? ST_IDLE : ST_POP;
        end else if (top_phase_q[0] && out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_POP:  state_d = ST_WALK;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    top_kind_d    = top_kind_q;
    top_phase_d   = top_phase_q;
    top_spine_d   = top_spine_q;
    depth_d       = depth_q;
    held_order_d  = held_order_q;
    held_length_d = held_length_q;
    active_d      = active_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_dx_d      = out_dx_q;
    out_dy_d      = out_dy_q;
    out_last_d    = out_last_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = depth_dec[AW-1:0];
    mem_raddr     = depth_dec2[AW-1:0];
    mem_wdata     = '{spine: top_spine_q, kind: top_kind_q, phase: top_phase_q + 3'd1};
    case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser[0] == REQ_START) begin
          held_order_d  = (in_order > 5'(MAX_ORDER)) ? DW'(MAX_ORDER) : DW'(in_order);
          held_length_d = s_axis_tdata[22:7];
          if (in_order == 5'd0) begin
            depth_d  = '0;
            active_d = 1'b0;
          end else begin
            top_kind_d  = kind_e'(s_axis_tdata[6:5]);
            top_phase_d = 3'd0;
            top_spine_d = 1'b1;
            depth_d     = DW'(1);
            active_d    = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (top_phase_q == PHASE_DONE) begin
          depth_d = depth_dec;
          if (depth_q == DW'(1)) begin
            active_d = 1'b0;
          end else begin
            mem_re = 1'b1;
          end
        end else if (!top_phase_q[0]) begin
          top_phase_d = top_phase_q + 3'd1;
          if (!at_leaf && depth_q < DW'(MAX_ORDER)) begin
            mem_we      = 1'b1;
            top_kind_d  = child_kind(top_kind_q, top_phase_q[2:1]);
            top_phase_d = 3'd0;
            top_spine_d = top_spine_q && (top_phase_q == PHASE_TAIL);
            depth_d     = depth_q + DW'(1);
          end
        end else if (out_free) begin
          top_phase_d = top_phase_q + 3'd1;
          out_valid_d = 1'b1;
          out_last_d  = is_last;
          out_dx_d    = (dir == DIR_RIGHT) ? len_pos : (dir == DIR_LEFT) ? len_neg : 17'd0;
          out_dy_d    = (dir == DIR_UP)    ? len_pos : (dir == DIR_DOWN) ? len_neg : 17'd0;
          if (is_last) begin
            active_d = 1'b0;
            depth_d  = '0;
          end
        end
      end
      ST_POP: begin
        top_kind_d  = rd_q.kind;
        top_phase_d = rd_q.phase;
        top_spine_d = rd_q.spine;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= frame_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      depth_q       <= '0;
      held_order_q  <= '0;
      held_length_q <= '0;
      active_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      depth_q       <= depth_d;
      held_order_q  <= held_order_d;
      held_length_q <= held_length_d;
      active_q      <= active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_kind_q  <= top_kind_d;
    top_phase_q <= top_phase_d;
    top_spine_q <= top_spine_d;
    out_dx_q    <= out_dx_d;
    out_dy_q    <= out_dy_d;
    out_last_q  <= out_last_d;
  end

  a_active_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (depth_q != '0) && (depth_q <= DW'(MAX_ORDER)))
    else $error("active curve with empty or overfull stack");

  a_walk_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> active_q)
    else $error("walk running without an active curve");

  a_rise_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_WALK)
    else $error("result word not produced by a move step");

  a_depth_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> depth_q <= held_order_q)
    else $error("stack deeper than curve order");

endmodule
